// ===== src/hbbc_pkg.sv =====
// Package: action and status codes shared by the buffer cache modules.
package hbbc_pkg;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  localparam int unsigned BlockBits = 32;
  localparam int unsigned DevBits   = 32;

endpackage

// ===== src/hbbc_mod.sv =====
// Block number modulo unit: one byte per cycle, reduced by a reciprocal multiply.
module hbbc_mod #(
  parameter int unsigned NUM_BUCKETS = 13,
  parameter int unsigned BKT_W       = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [hbbc_pkg::BlockBits-1:0] value_i,
  output logic                           done_o,
  output logic [BKT_W-1:0]               rem_o
);
  localparam int unsigned Steps = hbbc_pkg::BlockBits / 8;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned TW    = BKT_W + 8;
  localparam int unsigned Shift = TW + BKT_W;
  localparam int unsigned PW    = TW + Shift + 1;
  // ceil(2^Shift / NUM_BUCKETS): exact quotient for any partial below 2^TW
  localparam longint unsigned RecipVal =
    ((64'd1 << Shift) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [Shift:0] Recip   = (Shift + 1)'(RecipVal);
  localparam logic [TW-1:0]  Divisor = TW'(NUM_BUCKETS);

  logic [hbbc_pkg::BlockBits-1:0] val_q, val_d;
  logic [BKT_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [TW-1:0]    part;
  logic [PW-1:0]    prod;
  logic [7:0]       quot;
  logic [TW-1:0]    back;
  logic [TW-1:0]    diff;

  // fold the next byte into the running remainder, most significant byte first
  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    part   = {rem_q, val_q[hbbc_pkg::BlockBits-1 -: 8]};
    prod   = {{(Shift + 1){1'b0}}, part} * {{TW{1'b0}}, Recip};
    quot   = prod[Shift +: 8];
    back   = {{(TW - 8){1'b0}}, quot} * Divisor;
    diff   = part - back;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[hbbc_pkg::BlockBits-9:0], 8'd0};
      rem_d = diff[BKT_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign rem_o  = rem_d;

endmodule

// ===== src/hashed_block_buffer_cache.sv =====
// Top level: hashed buffer cache with reference counts and list sequencer.
//
// Usage: one request per transaction on the s_axis channel; tdata packs
// action[1:0], device[33:2], block_number[65:34], buffer_index[70:66].
// One response per request on m_axis; tdata packs result_index[4:0], hit[5],
// needs_read[6], status[8:7]. The block takes one request at a time and
// holds s_axis_tready low until the response has been handed off.
// A get first runs the modulo unit, which takes one byte of the block number
// at a time, then walks its bucket one entry a cycle; on a miss it walks the
// buckets in turn from bucket 0 for a free entry, then walks the victim's
// bucket to unlink it. The walks share one link-follow/compare unit. Reset
// restores the tables at once (valid and count cleared, all entries chained
// in bucket 0); no clearing pass. When the receiver stalls, the response is
// held in the output register and no new request is taken.
module hashed_block_buffer_cache #(
  parameter int unsigned NUM_BUFFERS   = 32,
  parameter int unsigned NUM_BUCKETS   = 13,
  parameter int unsigned REFCOUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // action, device, block_number, buffer_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // result_index, hit, needs_read, status
);
  localparam int unsigned IdxW  = $clog2(NUM_BUFFERS);
  localparam int unsigned LinkW = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned BktW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [LinkW-1:0] LinkNull = LinkW'(NUM_BUFFERS);
  localparam logic [REFCOUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MOD    = 8'b00000010,
    S_SEARCH = 8'b00000100,
    S_SCAN   = 8'b00001000,
    S_UNLINK = 8'b00010000,
    S_FIX    = 8'b00100000,
    S_CNT    = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [hbbc_pkg::DevBits-1:0]   dev_mem [NUM_BUFFERS];
  logic [hbbc_pkg::BlockBits-1:0] blk_mem [NUM_BUFFERS];
  logic [REFCOUNT_BITS-1:0]       cnt_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]         valid_q;
  logic [LinkW-1:0]               next_q [NUM_BUFFERS];
  logic [LinkW-1:0]               head_q [NUM_BUCKETS];

  logic [1:0]                     act_q;
  logic [hbbc_pkg::DevBits-1:0]   dev_q;
  logic [hbbc_pkg::BlockBits-1:0] blk_q;
  logic [4:0]                     bidx_q;
  logic [IdxW-1:0]                bidx;
  logic [BktW-1:0]                bkt_q, scan_bkt_q;
  logic [LinkW-1:0]               cur_q, prev_q, victim_q;
  logic [IdxW-1:0]                cur_i;
  logic [4:0]                     r_idx_q;
  logic                           r_hit_q, r_rd_q;
  logic [1:0]                     r_st_q;

  logic                           mod_start, mod_done;
  logic [BktW-1:0]                mod_rem;
  logic                           accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'd0, r_st_q, r_rd_q, r_hit_q, r_idx_q};
  assign mod_start     = accept && (s_axis_tdata[1:0] == hbbc_pkg::ACT_GET);
  assign cur_i         = cur_q[IdxW-1:0];
  assign bidx          = IdxW'(bidx_q);

  hbbc_mod #(.NUM_BUCKETS(NUM_BUCKETS), .BKT_W(BktW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (s_axis_tdata[65:34]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // sequencer: one list step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        cnt_q[i]  <= '0;
        next_q[i] <= (i == 0) ? LinkNull : LinkW'(i - 1);
      end
      for (int b = 0; b < NUM_BUCKETS; b++)
        head_q[b] <= (b == 0) ? LinkW'(NUM_BUFFERS - 1) : LinkNull;
      act_q <= '0; dev_q <= '0; blk_q <= '0; bidx_q <= '0;
      bkt_q <= '0; scan_bkt_q <= '0; cur_q <= '0; prev_q <= '0; victim_q <= '0;
      r_idx_q <= '0; r_hit_q <= 1'b0; r_rd_q <= 1'b0; r_st_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q  <= s_axis_tdata[1:0];
            dev_q  <= s_axis_tdata[33:2];
            blk_q  <= s_axis_tdata[65:34];
            bidx_q <= s_axis_tdata[70:66];
            state_q <= (s_axis_tdata[1:0] == hbbc_pkg::ACT_GET) ? S_MOD : S_CNT;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bkt_q   <= mod_rem;
            cur_q   <= head_q[mod_rem];
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (cur_q == LinkNull) begin
            scan_bkt_q <= '0;
            cur_q      <= head_q[0];
            state_q    <= S_SCAN;
          end else if (dev_mem[cur_i] == dev_q && blk_mem[cur_i] == blk_q) begin
            r_idx_q <= 5'(cur_q);
            r_hit_q <= 1'b1;
            r_rd_q  <= ~valid_q[cur_i];
            valid_q[cur_i] <= 1'b1;
            if (cnt_q[cur_i] == CountMax) r_st_q <= hbbc_pkg::ST_OVERFLOW;
            else begin
              cnt_q[cur_i] <= cnt_q[cur_i] + 1'b1;
              r_st_q <= hbbc_pkg::ST_OK;
            end
            state_q <= S_OUT;
          end else begin
            cur_q <= next_q[cur_i];
          end
        end
        S_SCAN: begin
          if (cur_q == LinkNull) begin
            if (32'(scan_bkt_q) == NUM_BUCKETS - 1) begin
              r_idx_q <= '0; r_hit_q <= 1'b0; r_rd_q <= 1'b0;
              r_st_q  <= hbbc_pkg::ST_NO_FREE;
              state_q <= S_OUT;
            end else begin
              scan_bkt_q <= scan_bkt_q + 1'b1;
              cur_q      <= head_q[scan_bkt_q + 1'b1];
            end
          end else if (cnt_q[cur_i] == '0) begin
            victim_q <= cur_q;
            prev_q   <= LinkNull;
            cur_q    <= head_q[scan_bkt_q];
            state_q  <= S_UNLINK;
          end else begin
            cur_q <= next_q[cur_i];
          end
        end
        S_UNLINK: begin
          // victim is known to be on this list
          if (cur_q == victim_q) begin
            if (prev_q == LinkNull) head_q[scan_bkt_q] <= next_q[cur_i];
            else next_q[prev_q[IdxW-1:0]] <= next_q[cur_i];
            state_q <= S_FIX;
          end else begin
            prev_q <= cur_q;
            cur_q  <= next_q[cur_i];
          end
        end
        S_FIX: begin
          next_q[victim_q[IdxW-1:0]] <= head_q[bkt_q];
          head_q[bkt_q]              <= victim_q;
          cnt_q[victim_q[IdxW-1:0]]  <= REFCOUNT_BITS'(1);
          valid_q[victim_q[IdxW-1:0]] <= 1'b1;
          r_idx_q <= 5'(victim_q);
          r_hit_q <= 1'b0; r_rd_q <= 1'b1; r_st_q <= hbbc_pkg::ST_OK;
          state_q <= S_OUT;
        end
        S_CNT: begin
          r_idx_q <= bidx_q; r_hit_q <= 1'b0; r_rd_q <= 1'b0;
          r_st_q  <= hbbc_pkg::ST_OK;
          if (32'(bidx_q) < NUM_BUFFERS) begin
            if (act_q == hbbc_pkg::ACT_PIN) begin
              if (cnt_q[bidx] == CountMax) r_st_q <= hbbc_pkg::ST_OVERFLOW;
              else cnt_q[bidx] <= cnt_q[bidx] + 1'b1;
            end else begin
              if (cnt_q[bidx] == '0) r_st_q <= hbbc_pkg::ST_UNDERFLOW;
              else cnt_q[bidx] <= cnt_q[bidx] - 1'b1;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // tag store: written only when a victim is retagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        dev_mem[i] <= '0;
        blk_mem[i] <= '0;
      end
    end else if (state_q == S_FIX) begin
      dev_mem[victim_q[IdxW-1:0]] <= dev_q;
      blk_mem[victim_q[IdxW-1:0]] <= blk_q;
    end
  end

endmodule
